[hdl/dcf_pkg.sv]
// Shared constants and types of the dual consumer sensor record FIFO.
package dcf_pkg;

	localparam int DEPTH_DEFAULT = 64;

	localparam int OP_W  = 3;
	localparam int ID_W  = 16;
	localparam int VAL_W = 64;
	localparam int TS_W  = 64;
	localparam int ST_W  = 3;
	localparam int OCC_W = 7;
	localparam int BAR_W = 2;
	localparam int REC_W = ID_W + VAL_W + TS_W;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
	localparam logic [OP_W-1:0] OP_READ_A  = 3'd1;
	localparam logic [OP_W-1:0] OP_READ_B  = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE  = 3'd3;
	localparam logic [OP_W-1:0] OP_BARRIER = 3'd4;
	localparam logic [OP_W-1:0] OP_QUERY   = 3'd5;

	// status codes
	localparam logic [ST_W-1:0] ST_OK         = 3'd0;
	localparam logic [ST_W-1:0] ST_FAIL       = 3'd1;
	localparam logic [ST_W-1:0] ST_BOTH_NOW   = 3'd2;
	localparam logic [ST_W-1:0] ST_OTHER_PEND = 3'd3;
	localparam logic [ST_W-1:0] ST_AGAIN_PEND = 3'd4;
	localparam logic [ST_W-1:0] ST_BOTH_DONE  = 3'd5;

	// barrier status codes
	localparam logic [BAR_W-1:0] BAR_EMPTY = 2'd0;
	localparam logic [BAR_W-1:0] BAR_CLEAR = 2'd1;
	localparam logic [BAR_W-1:0] BAR_SET   = 2'd2;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [OCC_W-1:0] occupancy;
		logic [BAR_W-1:0] barrier;
		logic             first_read;
	} ctrl_res_t;

endpackage

[hdl/dcf_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module dcf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/dcf_ctrl.sv]
// Ring pointers, fill count and head marks of the FIFO, with operation decode.
module dcf_ctrl #(
	parameter int DEPTH = dcf_pkg::DEPTH_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [dcf_pkg::OP_W-1:0]     op,
	output dcf_pkg::ctrl_res_t           res,
	output logic                         wr_en,
	output logic [$clog2(DEPTH)-1:0]     wr_addr,
	output logic                         rd_en,
	output logic [$clog2(DEPTH)-1:0]     rd_addr
);
	import dcf_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	logic [PW-1:0] rd_ptr_q, wr_ptr_q, rd_ptr_d, wr_ptr_d;
	logic [CW-1:0] count_q, count_d;
	logic          done_a_q, done_b_q, barrier_q;
	logic          done_a_d, done_b_d, barrier_d;
	logic          mine, other, do_write, do_read;
	logic [ST_W-1:0] status;

	always_comb begin
		rd_ptr_d  = rd_ptr_q;
		wr_ptr_d  = wr_ptr_q;
		count_d   = count_q;
		done_a_d  = done_a_q;
		done_b_d  = done_b_q;
		barrier_d = barrier_q;
		do_write  = 1'b0;
		do_read   = 1'b0;
		status    = ST_OK;
		mine      = (op == OP_READ_A) ? done_a_q : done_b_q;
		other     = (op == OP_READ_A) ? done_b_q : done_a_q;
		case (op)
			OP_INSERT: begin
				if (count_q == FULL) begin
					status = ST_FAIL;
				end else begin
					do_write = 1'b1;
					wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
					count_d  = count_q + 1'b1;
					if (count_q == '0) begin
						done_a_d  = 1'b0;
						done_b_d  = 1'b0;
						barrier_d = 1'b0;
					end
				end
			end
			OP_READ_A, OP_READ_B: begin
				if (count_q == '0) begin
					status = ST_FAIL;
				end else if (!mine) begin
					do_read = 1'b1;
					status  = other ? ST_BOTH_NOW : ST_OTHER_PEND;
					if (op == OP_READ_A) begin
						done_a_d = 1'b1;
					end else begin
						done_b_d = 1'b1;
					end
				end else begin
					status = other ? ST_BOTH_DONE : ST_AGAIN_PEND;
				end
			end
			OP_REMOVE: begin
				if (count_q == '0) begin
					status = ST_FAIL;
				end else begin
					rd_ptr_d  = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
					count_d   = count_q - 1'b1;
					done_a_d  = 1'b0;
					done_b_d  = 1'b0;
					barrier_d = 1'b0;
				end
			end
			OP_BARRIER: begin
				if (count_q == '0) begin
					status = ST_FAIL;
				end else begin
					barrier_d = 1'b1;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	assign res.status     = status;
	assign res.occupancy  = OCC_W'(count_d);
	assign res.barrier    = (count_d == '0) ? BAR_EMPTY : (barrier_d ? BAR_SET : BAR_CLEAR);
	assign res.first_read = do_read;

	assign wr_en   = accept && do_write;
	assign wr_addr = wr_ptr_q;
	assign rd_en   = accept && do_read;
	assign rd_addr = rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q  <= '0;
			wr_ptr_q  <= '0;
			count_q   <= '0;
			done_a_q  <= 1'b0;
			done_b_q  <= 1'b0;
			barrier_q <= 1'b0;
		end else if (accept) begin
			rd_ptr_q  <= rd_ptr_d;
			wr_ptr_q  <= wr_ptr_d;
			count_q   <= count_d;
			done_a_q  <= done_a_d;
			done_b_q  <= done_b_d;
			barrier_q <= barrier_d;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("fill count above depth");

	a_empty_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (!done_a_q && !done_b_q && !barrier_q))
		else $error("head marks set on an empty FIFO");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (count_q != FULL))
		else $error("record written while full");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == FULL) |-> (rd_ptr_q == wr_ptr_q))
		else $error("pointers disagree with fill count");

endmodule

[hdl/dual_consumer_fifo_top.sv]
// Top level of the dual consumer sensor record FIFO.
// Usage:
//  Input channel (in_valid/in_ready) carries one operation per beat: insert,
//  first or second consumer read, remove head, set head barrier, or query,
//  with the record fields used by insert. Output channel (out_valid/out_ready)
//  returns exactly one result beat per operation, in order: status, the head
//  record on a consumer's first read (zero otherwise), occupancy after the
//  operation and head barrier status.
//  Result path: an accepted operation passes the read stage, where the
//  memory's registered read port sits, and then the output register, which
//  drives the result beat and out_valid.
//  Throughput: one operation per cycle unless stalled. All bookkeeping
//  (pointers, count, done marks, barrier) updates in the accept cycle, so
//  the next operation sees it at once; the memory read happens then too.
//  Stall: a result waits in the output register while out_ready is low; one
//  more operation can sit in the read stage behind it, after which in_ready
//  drops until the output drains. The memory read data holds meanwhile.
//  Reset: arst_n clears pointers, count and marks; the FIFO is empty and
//  ready at once. Record memory contents are left undefined, as only
//  occupied entries are ever read.
module dual_consumer_fifo_top #(
	parameter int DEPTH = dcf_pkg::DEPTH_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [dcf_pkg::OP_W-1:0]  operation,
	input  logic [dcf_pkg::ID_W-1:0]  sensor_id,
	input  logic [dcf_pkg::VAL_W-1:0] sensor_value,
	input  logic [dcf_pkg::TS_W-1:0]  timestamp,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [dcf_pkg::ST_W-1:0]  status,
	output logic [dcf_pkg::ID_W-1:0]  out_sensor_id,
	output logic [dcf_pkg::VAL_W-1:0] out_sensor_value,
	output logic [dcf_pkg::TS_W-1:0]  out_timestamp,
	output logic [dcf_pkg::OCC_W-1:0] occupancy,
	output logic [dcf_pkg::BAR_W-1:0] barrier_status
);
	import dcf_pkg::*;

	localparam int PW = $clog2(DEPTH);

	ctrl_res_t       ctrl_res;
	ctrl_res_t       res_s1;
	logic            vld_s1;
	logic            accept, adv;
	logic            wr_en, rd_en;
	logic [PW-1:0]   wr_addr, rd_addr;
	logic [REC_W-1:0] wr_data, rd_data;

	logic             out_vld_q;
	logic [ST_W-1:0]  status_q;
	logic [ID_W-1:0]  id_q;
	logic [VAL_W-1:0] val_q;
	logic [TS_W-1:0]  ts_q;
	logic [OCC_W-1:0] occ_q;
	logic [BAR_W-1:0] bar_q;

	// advance the read stage whenever the output register is free or draining
	assign adv      = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || adv;
	assign accept   = in_valid && in_ready;

	assign wr_data = {sensor_id, sensor_value, timestamp};

	dcf_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.op      (operation),
		.res     (ctrl_res),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr)
	);

	dcf_ram #(.WIDTH(REC_W), .DEPTH(DEPTH)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers: hold while stalled, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= ctrl_res;
		end
		if (adv) begin
			status_q <= res_s1.status;
			occ_q    <= res_s1.occupancy;
			bar_q    <= res_s1.barrier;
			if (res_s1.first_read) begin
				id_q  <= rd_data[REC_W-1 -: ID_W];
				val_q <= rd_data[TS_W +: VAL_W];
				ts_q  <= rd_data[TS_W-1:0];
			end else begin
				id_q  <= '0;
				val_q <= '0;
				ts_q  <= '0;
			end
		end
	end

	assign out_valid        = out_vld_q;
	assign status           = status_q;
	assign out_sensor_id    = id_q;
	assign out_sensor_value = val_q;
	assign out_timestamp    = ts_q;
	assign occupancy        = occ_q;
	assign barrier_status   = bar_q;

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && out_vld_q && !out_ready) |-> !in_ready)
		else $error("operation accepted with both result slots full");

	a_read_once: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> accept)
		else $error("memory read outside an accepted beat");

	a_read_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv) |=> $stable(rd_data))
		else $error("read data lost while the read stage stalls");

endmodule

[test/tb_dual_consumer_fifo_top.sv]
// Testbench for the dual consumer sensor record FIFO: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_dual_consumer_fifo_top;
	import dcf_pkg::*;

	localparam int DEPTH       = DEPTH_DEFAULT;
	localparam int RANDOM_OPS  = 1925;
	localparam int CYCLE_LIMIT = 200000;
	localparam int GAP_PCT     = 14;

	// Codes six and seven are unused; the block answers them like a query.
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	typedef struct {
		logic [ST_W-1:0]  status;
		logic [ID_W-1:0]  sensor_id;
		logic [VAL_W-1:0] sensor_value;
		logic [TS_W-1:0]  timestamp;
		logic [OCC_W-1:0] occupancy;
		logic [BAR_W-1:0] barrier;
	} fifo_result_t;

	// One operation beat; fixed_answer rows carry their own expected result.
	typedef struct {
		logic [OP_W-1:0]  operation;
		logic [ID_W-1:0]  sensor_id;
		logic [VAL_W-1:0] sensor_value;
		logic [TS_W-1:0]  timestamp;
		bit               fixed_answer;
		fifo_result_t     answer;
	} op_beat_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [OP_W-1:0]   operation = OP_QUERY;
	logic [ID_W-1:0]   sensor_id = '0;
	logic [VAL_W-1:0]  sensor_value = '0;
	logic [TS_W-1:0]   timestamp = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [ST_W-1:0]   status;
	logic [ID_W-1:0]   out_sensor_id;
	logic [VAL_W-1:0]  out_sensor_value;
	logic [TS_W-1:0]   out_timestamp;
	logic [OCC_W-1:0]  occupancy;
	logic [BAR_W-1:0]  barrier_status;

	int cycle_count = 0;
	int mismatch_count = 0;

	fifo_result_t pending_results[$];
	op_beat_t     directed_beats[$];

	// Shadow copy of the FIFO: ring memory, pointers, count and head marks.
	logic [ID_W-1:0]  shadow_id[DEPTH];
	logic [VAL_W-1:0] shadow_value[DEPTH];
	logic [TS_W-1:0]  shadow_stamp[DEPTH];
	int               shadow_rd = 0;
	int               shadow_wr = 0;
	int               shadow_count = 0;
	bit               shadow_done[2] = '{1'b0, 1'b0};
	bit               shadow_barrier = 1'b0;

	dual_consumer_fifo_top #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.operation        (operation),
		.sensor_id        (sensor_id),
		.sensor_value     (sensor_value),
		.timestamp        (timestamp),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.out_sensor_id    (out_sensor_id),
		.out_sensor_value (out_sensor_value),
		.out_timestamp    (out_timestamp),
		.occupancy        (occupancy),
		.barrier_status   (barrier_status)
	);

	always #2 clk = ~clk;

	// Cycle counter doubles as the watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// A window in the middle of the run where neither side ever pauses.
	function automatic bit take_gap();
		if (cycle_count >= 1200 && cycle_count < 1800)
			return 1'b0;
		return $urandom_range(99) < GAP_PCT;
	endfunction

	function automatic op_beat_t make_beat(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
			input logic [VAL_W-1:0] val, input logic [TS_W-1:0] ts, input int fixed,
			input logic [ST_W-1:0] st, input int occ, input logic [BAR_W-1:0] bar);
		op_beat_t b;
		b.operation    = op;
		b.sensor_id    = id;
		b.sensor_value = val;
		b.timestamp    = ts;
		b.fixed_answer = (fixed != 0);
		b.answer       = '{st, '0, '0, '0, OCC_W'(occ), bar};
		return b;
	endfunction

	// Apply one operation to the shadow FIFO and return the result it must produce.
	function automatic fifo_result_t apply_operation(input op_beat_t b);
		fifo_result_t r;
		int           mine;
		r    = '{ST_OK, '0, '0, '0, '0, BAR_EMPTY};
		mine = (b.operation == OP_READ_A) ? 0 : 1;
		case (b.operation)
			OP_INSERT: begin
				if (shadow_count >= DEPTH) begin
					r.status = ST_FAIL;
				end else begin
					shadow_id[shadow_wr]    = b.sensor_id;
					shadow_value[shadow_wr] = b.sensor_value;
					shadow_stamp[shadow_wr] = b.timestamp;
					shadow_wr = (shadow_wr + 1) % DEPTH;
					// a record landing in an empty FIFO becomes a fresh head
					if (shadow_count == 0) begin
						shadow_done    = '{1'b0, 1'b0};
						shadow_barrier = 1'b0;
					end
					shadow_count++;
				end
			end
			OP_READ_A, OP_READ_B: begin
				if (shadow_count == 0) begin
					r.status = ST_FAIL;
				end else if (!shadow_done[mine]) begin
					r.sensor_id    = shadow_id[shadow_rd];
					r.sensor_value = shadow_value[shadow_rd];
					r.timestamp    = shadow_stamp[shadow_rd];
					shadow_done[mine] = 1'b1;
					r.status = shadow_done[1 - mine] ? ST_BOTH_NOW : ST_OTHER_PEND;
				end else begin
					// repeated read returns no record
					r.status = shadow_done[1 - mine] ? ST_BOTH_DONE : ST_AGAIN_PEND;
				end
			end
			OP_REMOVE: begin
				if (shadow_count == 0) begin
					r.status = ST_FAIL;
				end else begin
					shadow_rd = (shadow_rd + 1) % DEPTH;
					shadow_count--;
					shadow_done    = '{1'b0, 1'b0};
					shadow_barrier = 1'b0;
				end
			end
			OP_BARRIER: begin
				if (shadow_count == 0)
					r.status = ST_FAIL;
				else
					shadow_barrier = 1'b1;
			end
			default: begin
				// query and the spare codes change nothing
			end
		endcase
		r.occupancy = OCC_W'(shadow_count);
		r.barrier   = (shadow_count == 0) ? BAR_EMPTY : (shadow_barrier ? BAR_SET : BAR_CLEAR);
		return r;
	endfunction

	// Random operation; a fill phase leans on inserts, a drain phase on removes.
	function automatic op_beat_t random_beat(input bit filling);
		logic [OP_W-1:0] op;
		int              pick;
		pick = $urandom_range(99);
		if (filling)
			op = pick < 60 ? OP_INSERT : pick < 70 ? OP_READ_A : pick < 80 ? OP_READ_B :
				pick < 88 ? OP_REMOVE : pick < 93 ? OP_BARRIER : pick < 97 ? OP_QUERY :
				pick < 99 ? OP_SPARE_6 : OP_SPARE_7;
		else
			op = pick < 15 ? OP_INSERT : pick < 30 ? OP_READ_A : pick < 45 ? OP_READ_B :
				pick < 87 ? OP_REMOVE : pick < 93 ? OP_BARRIER : pick < 97 ? OP_QUERY :
				pick < 99 ? OP_SPARE_6 : OP_SPARE_7;
		return make_beat(op, ID_W'($urandom_range(0, 65535)), {$urandom, $urandom},
			{$urandom, $urandom}, 0, ST_OK, 0, BAR_EMPTY);
	endfunction

	// Present one beat from the falling edge, hold it until accepted, log its result.
	task automatic send_beat(input op_beat_t b);
		fifo_result_t predicted;
		while (take_gap()) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid     = 1'b1;
		operation    = b.operation;
		sensor_id    = b.sensor_id;
		sensor_value = b.sensor_value;
		timestamp    = b.timestamp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = apply_operation(b);
		pending_results.push_back(b.fixed_answer ? b.answer : predicted);
		@(negedge clk);
	endtask

	// Drop valid and hold off until every outstanding result has come back.
	task automatic hold_until_drained();
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// Output side: compare each accepted result beat with the oldest expectation.
	always @(posedge clk) begin : check_results
		fifo_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected: status %0d", status);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 64'(want.status), 64'(status));
				check_field("out_sensor_id", 64'(want.sensor_id), 64'(out_sensor_id));
				check_field("out_sensor_value", want.sensor_value, out_sensor_value);
				check_field("out_timestamp", want.timestamp, out_timestamp);
				check_field("occupancy", 64'(want.occupancy), 64'(occupancy));
				check_field("barrier_status", 64'(want.barrier), 64'(barrier_status));
			end
		end
	end

	// Receiver: stall now and then, changing ready only at the falling edge.
	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			out_ready = !take_gap();
		end
	end

	// Sender: reset, directed table, random traffic, then wind down.
	initial begin : drive_operations
		bit filling;
		int phase_left;
		filling    = 1'b1;
		phase_left = 150;

		// Empty FIFO: every operation that needs a head must fail.
		directed_beats.push_back(make_beat(OP_QUERY, '0, '0, '0, 1, ST_OK, 0, BAR_EMPTY));
		directed_beats.push_back(make_beat(OP_READ_A, '0, '0, '0, 1, ST_FAIL, 0, BAR_EMPTY));
		directed_beats.push_back(make_beat(OP_READ_B, '0, '0, '0, 1, ST_FAIL, 0, BAR_EMPTY));
		directed_beats.push_back(make_beat(OP_REMOVE, '0, '0, '0, 1, ST_FAIL, 0, BAR_EMPTY));
		directed_beats.push_back(make_beat(OP_BARRIER, '0, '0, '0, 1, ST_FAIL, 0, BAR_EMPTY));
		directed_beats.push_back(make_beat(OP_SPARE_6, '1, '1, '1, 1, ST_OK, 0, BAR_EMPTY));
		directed_beats.push_back(make_beat(OP_SPARE_7, '1, '1, '1, 1, ST_OK, 0, BAR_EMPTY));
		// Extreme records, then both consumers read the head twice each.
		directed_beats.push_back(make_beat(OP_INSERT, '1, '1, '1, 1, ST_OK, 1, BAR_CLEAR));
		directed_beats.push_back(make_beat(OP_INSERT, '0, '0, '0, 1, ST_OK, 2, BAR_CLEAR));
		directed_beats.push_back(make_beat(OP_READ_A, '0, '0, '0, 0, ST_OK, 0, BAR_EMPTY));
		directed_beats.push_back(make_beat(OP_READ_A, '0, '0, '0, 0, ST_OK, 0, BAR_EMPTY));
		directed_beats.push_back(make_beat(OP_READ_B, '0, '0, '0, 0, ST_OK, 0, BAR_EMPTY));
		directed_beats.push_back(make_beat(OP_READ_B, '0, '0, '0, 0, ST_OK, 0, BAR_EMPTY));
		directed_beats.push_back(make_beat(OP_BARRIER, '0, '0, '0, 1, ST_OK, 2, BAR_SET));
		directed_beats.push_back(make_beat(OP_QUERY, '0, '0, '0, 1, ST_OK, 2, BAR_SET));
		// Remove clears the marks: the new head reads as fresh, second consumer first.
		directed_beats.push_back(make_beat(OP_REMOVE, '0, '0, '0, 1, ST_OK, 1, BAR_CLEAR));
		directed_beats.push_back(make_beat(OP_READ_B, '0, '0, '0, 0, ST_OK, 0, BAR_EMPTY));
		directed_beats.push_back(make_beat(OP_READ_A, '0, '0, '0, 0, ST_OK, 0, BAR_EMPTY));
		directed_beats.push_back(make_beat(OP_REMOVE, '0, '0, '0, 1, ST_OK, 0, BAR_EMPTY));
		directed_beats.push_back(make_beat(OP_BARRIER, '0, '0, '0, 1, ST_FAIL, 0, BAR_EMPTY));
		// Alternating bit patterns, written at ring positions two and three.
		directed_beats.push_back(make_beat(OP_INSERT, 16'hA5A5, {16{4'h5}}, {16{4'hA}},
			1, ST_OK, 1, BAR_CLEAR));
		directed_beats.push_back(make_beat(OP_INSERT, 16'h5A5A, {16{4'hA}}, {16{4'h5}},
			1, ST_OK, 2, BAR_CLEAR));
		directed_beats.push_back(make_beat(OP_BARRIER, '0, '0, '0, 1, ST_OK, 2, BAR_SET));
		directed_beats.push_back(make_beat(OP_READ_A, '0, '0, '0, 0, ST_OK, 0, BAR_EMPTY));
		directed_beats.push_back(make_beat(OP_REMOVE, '0, '0, '0, 1, ST_OK, 1, BAR_CLEAR));

		// Hold reset, then release it on a falling edge.
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_beats[i])
			send_beat(directed_beats[i]);
		hold_until_drained();

		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (phase_left == 0) begin
				filling    = !filling;
				phase_left = $urandom_range(120, 260);
			end
			phase_left--;
			// one more full drain partway through, with the FIFO likely busy
			if (n == RANDOM_OPS / 2)
				hold_until_drained();
			send_beat(random_beat(filling));
		end

		hold_until_drained();
		// leave room for a stray beat to show up
		repeat (8) @(negedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
hdl/dcf_pkg.sv
hdl/dcf_ram.sv
hdl/dcf_ctrl.sv
hdl/dual_consumer_fifo_top.sv
test/tb_dual_consumer_fifo_top.sv
